[hw/rtl/log_text_utf8_normalizer_defines.svh]
// assertion helpers for the log text normaliser
`ifndef LOG_TEXT_UTF8_NORMALIZER_DEFINES_SVH
`define LOG_TEXT_UTF8_NORMALIZER_DEFINES_SVH

// same-cycle implication, off while in reset
`define LTN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ltn assertion failed");

// next-cycle implication, off while in reset
`define LTN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ltn assertion failed");

`endif

[hw/rtl/ltn_pkg.sv]
package ltn_pkg;

    localparam int WS_DEPTH   = 32;
    localparam int BCNT_W     = $clog2(WS_DEPTH + 1);
    localparam int BIDX_W     = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] LEAD_MIN = 8'hC2;
    localparam logic [7:0] LEAD_3B  = 8'hE0;
    localparam logic [7:0] LEAD_4B  = 8'hF0;

    localparam logic [1:0] BM_NONE  = 2'd0;
    localparam logic [1:0] BM_RAW   = 2'd1;
    localparam logic [1:0] BM_LATIN = 2'd2;

    // everything one item asks of the back end, in emission order
    typedef struct packed {
        logic [1:0]        held_cnt;
        logic              held_latin;
        logic [2:0][7:0]   held;
        logic              nl_pre;
        logic [BCNT_W-1:0] blank_cnt;
        logic [1:0]        byte_mode;
        logic [7:0]        data;
        logic              nl_end;
        logic              bare;
        logic              msg_end;
        logic              ovf;
        logic              wr_en;
        logic [BIDX_W-1:0] wr_idx;
        logic              wr_tab;
    } cmd_t;

    function automatic logic [7:0] latin_hi(input logic [7:0] b);
        return {6'b110000, b[7:6]};
    endfunction

    function automatic logic [7:0] latin_lo(input logic [7:0] b);
        return {2'b10, b[5:0]};
    endfunction

endpackage

[hw/rtl/ltn_channels.sv]
interface ltn_raw_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface ltn_norm_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       run_last;
    logic       message_done;
    logic       ws_overflow;

    modport source (output valid, output out_byte, output out_valid, output run_last,
                    output message_done, output ws_overflow, input ready);
    modport sink (input valid, input out_byte, input out_valid, input run_last,
                  input message_done, input ws_overflow, output ready);
endinterface

[hw/rtl/ltn_ram.sv]
module ltn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/ltn_cmd_fifo.sv]
module ltn_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ltn_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output ltn_pkg::cmd_t head
);

    ltn_pkg::cmd_t                     entries_reg [ltn_pkg::CMDQ_DEPTH];
    logic [ltn_pkg::CMDQ_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [ltn_pkg::CMDQ_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [ltn_pkg::CMDQ_CW-1:0]       cnt_reg, cnt_next;
    logic                              do_push, do_pop;

    assign full    = (cnt_reg == ltn_pkg::CMDQ_CW'(ltn_pkg::CMDQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == ltn_pkg::CMDQ_AW'(ltn_pkg::CMDQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + ltn_pkg::CMDQ_AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ltn_pkg::CMDQ_AW'(ltn_pkg::CMDQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + ltn_pkg::CMDQ_AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + ltn_pkg::CMDQ_CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - ltn_pkg::CMDQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/ltn_front.sv]
module ltn_front (
    input  logic           clk,
    input  logic           rst_n,
    ltn_raw_if.sink        raw,
    input  logic           q_full,
    output logic           push,
    output ltn_pkg::cmd_t  cmd
);

    logic [ltn_pkg::BCNT_W-1:0] bcnt_reg, bcnt_next;
    logic [2:0][7:0]            sb_reg, sb_next;
    logic [1:0]                 sh_reg, sh_next;
    logic [1:0]                 sn_reg, sn_next;
    logic                       lht_reg, lht_next;
    logic                       bls_reg, bls_next;
    logic                       ae_reg, ae_next;
    logic                       acr_reg, acr_next;
    logic                       ovf_reg, ovf_next;
    logic                       accept;
    logic                       started;
    logic [7:0]                 b;
    ltn_pkg::cmd_t              c;

    assign raw.ready = !q_full;
    assign accept    = raw.valid && !q_full;
    assign cmd       = c;

    always_comb
    begin
        c         = '0;
        bcnt_next = bcnt_reg;
        sb_next   = sb_reg;
        sh_next   = sh_reg;
        sn_next   = sn_reg;
        lht_next  = lht_reg;
        bls_next  = bls_reg;
        ae_next   = ae_reg;
        acr_next  = acr_reg;
        ovf_next  = ovf_reg;
        started   = 1'b0;
        b         = raw.data_byte;
        c.data    = b;
        c.held    = sb_reg;

        if (raw.byte_present)
        begin
            if (b == ltn_pkg::CH_LF && acr_reg)
            begin
                // LF of a CR LF pair
                acr_next = 1'b0;
            end
            else
            begin
                acr_next = (b == ltn_pkg::CH_CR);
                if (b == ltn_pkg::CH_LF || b == ltn_pkg::CH_CR)
                begin
                    if (sh_reg != 2'd0)
                    begin
                        c.held_cnt   = sh_reg;
                        c.held_latin = 1'b1;
                        ae_next      = 1'b1;
                    end
                    sh_next = 2'd0;
                    sn_next = 2'd0;
                    if (lht_reg)
                    begin
                        c.nl_pre = 1'b1;
                        ae_next  = 1'b1;
                    end
                    else
                    begin
                        bls_next = 1'b1;
                    end
                    bcnt_next = '0;
                    lht_next  = 1'b0;
                end
                else if (b == ltn_pkg::CH_SP || b == ltn_pkg::CH_TAB)
                begin
                    if (sh_reg != 2'd0)
                    begin
                        c.held_cnt   = sh_reg;
                        c.held_latin = 1'b1;
                        ae_next      = 1'b1;
                    end
                    sh_next = 2'd0;
                    sn_next = 2'd0;
                    if (bcnt_reg < ltn_pkg::BCNT_W'(ltn_pkg::WS_DEPTH))
                    begin
                        c.wr_en   = 1'b1;
                        c.wr_idx  = bcnt_reg[ltn_pkg::BIDX_W-1:0];
                        c.wr_tab  = (b == ltn_pkg::CH_TAB);
                        bcnt_next = bcnt_reg + ltn_pkg::BCNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else if (sh_reg != 2'd0 && b[7:6] == 2'b10)
                begin
                    if (sh_reg >= sn_reg)
                    begin
                        // sequence complete, pass it through
                        c.held_cnt   = sh_reg;
                        c.held_latin = 1'b0;
                        c.byte_mode  = ltn_pkg::BM_RAW;
                        ae_next      = 1'b1;
                        sh_next      = 2'd0;
                        sn_next      = 2'd0;
                    end
                    else
                    begin
                        case (sh_reg)
                            2'd1:    sb_next[1] = b;
                            2'd2:    sb_next[2] = b;
                            default: sb_next[0] = b;
                        endcase
                        sh_next = sh_reg + 2'd1;
                    end
                end
                else
                begin
                    if (sh_reg != 2'd0)
                    begin
                        c.held_cnt   = sh_reg;
                        c.held_latin = 1'b1;
                        ae_next      = 1'b1;
                    end
                    sh_next = 2'd0;
                    sn_next = 2'd0;
                    if (!lht_reg)
                    begin
                        if (bls_reg && ae_next)
                        begin
                            c.nl_pre = 1'b1;
                        end
                        bls_next = 1'b0;
                        lht_next = 1'b1;
                    end
                    c.blank_cnt = bcnt_reg;
                    if (bcnt_reg != '0)
                    begin
                        ae_next = 1'b1;
                    end
                    bcnt_next = '0;
                    if (!b[7])
                    begin
                        c.byte_mode = ltn_pkg::BM_RAW;
                        ae_next     = 1'b1;
                    end
                    else if (b >= ltn_pkg::LEAD_MIN && b <= ltn_pkg::LEAD_4B)
                    begin
                        sb_next[0] = b;
                        sh_next    = 2'd1;
                        sn_next    = (b < ltn_pkg::LEAD_3B) ? 2'd1 :
                                     (b < ltn_pkg::LEAD_4B) ? 2'd2 : 2'd3;
                        started    = 1'b1;
                    end
                    else
                    begin
                        c.byte_mode = ltn_pkg::BM_LATIN;
                        ae_next     = 1'b1;
                    end
                end
            end
        end

        if (raw.end_of_message)
        begin
            // an unfinished sequence leaves as latin-1 before nl_end
            if (sh_next != 2'd0)
            begin
                if (started)
                begin
                    c.byte_mode = ltn_pkg::BM_LATIN;
                end
                else
                begin
                    c.held_cnt   = sh_next;
                    c.held_latin = 1'b1;
                    c.held       = sb_next;
                end
            end
            c.nl_end = lht_next;
            c.bare   = !(c.held_cnt != 2'd0 || c.nl_pre || c.blank_cnt != '0 ||
                         c.byte_mode != ltn_pkg::BM_NONE || c.nl_end);
        end
        c.msg_end = raw.end_of_message;
        c.ovf     = ovf_next;

        push = accept && (c.held_cnt != 2'd0 || c.nl_pre || c.blank_cnt != '0 ||
                          c.byte_mode != ltn_pkg::BM_NONE || c.nl_end || c.bare ||
                          c.wr_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcnt_reg <= '0;
            sh_reg   <= 2'd0;
            sn_reg   <= 2'd0;
            lht_reg  <= 1'b0;
            bls_reg  <= 1'b0;
            ae_reg   <= 1'b0;
            acr_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (raw.end_of_message)
            begin
                bcnt_reg <= '0;
                sh_reg   <= 2'd0;
                sn_reg   <= 2'd0;
                lht_reg  <= 1'b0;
                bls_reg  <= 1'b0;
                ae_reg   <= 1'b0;
                acr_reg  <= 1'b0;
                ovf_reg  <= 1'b0;
            end
            else
            begin
                bcnt_reg <= bcnt_next;
                sh_reg   <= sh_next;
                sn_reg   <= sn_next;
                lht_reg  <= lht_next;
                bls_reg  <= bls_next;
                ae_reg   <= ae_next;
                acr_reg  <= acr_next;
                ovf_reg  <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sb_reg <= sb_next;
        end
    end

endmodule

[hw/rtl/ltn_back.sv]
`include "log_text_utf8_normalizer_defines.svh"

module ltn_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  ltn_pkg::cmd_t q_head,
    output logic          pop,
    ltn_norm_if.source    norm
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_HELD  = 3'd1;
    localparam logic [2:0] ST_NLPRE = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_BLANK = 3'd4;
    localparam logic [2:0] ST_BYTE  = 3'd5;
    localparam logic [2:0] ST_NLEND = 3'd6;
    localparam logic [2:0] ST_BARE  = 3'd7;

    // earliest phase at or after 'from' that has something to send
    function automatic logic [2:0] first_phase(input ltn_pkg::cmd_t c, input logic [3:0] from);
        logic [2:0] p;
        p = ST_IDLE;
        if ({1'b0, ST_BARE} >= from && c.bare)
            p = ST_BARE;
        if ({1'b0, ST_NLEND} >= from && c.nl_end)
            p = ST_NLEND;
        if ({1'b0, ST_BYTE} >= from && c.byte_mode != ltn_pkg::BM_NONE)
            p = ST_BYTE;
        if ({1'b0, ST_RD} >= from && c.blank_cnt != '0)
            p = ST_RD;
        if ({1'b0, ST_NLPRE} >= from && c.nl_pre)
            p = ST_NLPRE;
        if ({1'b0, ST_HELD} >= from && c.held_cnt != 2'd0)
            p = ST_HELD;
        return p;
    endfunction

    logic [2:0]                 state_reg;
    ltn_pkg::cmd_t              cmd_reg;
    logic [1:0]                 k_reg;
    logic                       half_reg;
    logic [ltn_pkg::BCNT_W-1:0] idx_reg;
    logic [ltn_pkg::BCNT_W-1:0] idx_inc;
    logic                       ovld_reg;
    logic [7:0]                 obyte_reg;
    logic                       oval_reg, olast_reg, odone_reg, oovf_reg;

    logic                       emit_ok, produce, emit;
    logic                       phase_done, unit_done, is_last;
    logic [7:0]                 res_byte, held_b;
    logic                       res_val;
    logic [2:0]                 next_after;
    logic [ltn_pkg::BIDX_W-1:0] raddr;
    logic                       rdata;

    ltn_ram #(.WIDTH(1), .DEPTH(ltn_pkg::WS_DEPTH)) u_blank_ram (
        .clk   (clk),
        .we    (pop && q_head.wr_en),
        .waddr (q_head.wr_idx),
        .wdata (q_head.wr_tab),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign norm.valid        = ovld_reg;
    assign norm.out_byte     = obyte_reg;
    assign norm.out_valid    = oval_reg;
    assign norm.run_last     = olast_reg;
    assign norm.message_done = odone_reg;
    assign norm.ws_overflow  = oovf_reg;

    assign idx_inc = idx_reg + ltn_pkg::BCNT_W'(1);

    always_comb
    begin
        emit_ok    = !ovld_reg || norm.ready;
        pop        = 1'b0;
        produce    = 1'b0;
        res_byte   = 8'h00;
        res_val    = 1'b1;
        phase_done = 1'b0;
        unit_done  = 1'b1;
        case (k_reg)
            2'd1:    held_b = cmd_reg.held[1];
            2'd2:    held_b = cmd_reg.held[2];
            default: held_b = cmd_reg.held[0];
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                pop = !q_empty;
            end
            ST_HELD:
            begin
                produce = 1'b1;
                if (cmd_reg.held_latin)
                begin
                    res_byte  = half_reg ? ltn_pkg::latin_lo(held_b) : ltn_pkg::latin_hi(held_b);
                    unit_done = half_reg;
                end
                else
                begin
                    res_byte = held_b;
                end
                phase_done = unit_done && (k_reg == cmd_reg.held_cnt - 2'd1);
            end
            ST_NLPRE:
            begin
                produce    = 1'b1;
                res_byte   = ltn_pkg::CH_LF;
                phase_done = 1'b1;
            end
            ST_RD:
            begin
                produce = 1'b0;
            end
            ST_BLANK:
            begin
                produce    = 1'b1;
                res_byte   = rdata ? ltn_pkg::CH_TAB : ltn_pkg::CH_SP;
                phase_done = (idx_inc == cmd_reg.blank_cnt);
            end
            ST_BYTE:
            begin
                produce = 1'b1;
                if (cmd_reg.byte_mode == ltn_pkg::BM_LATIN)
                begin
                    res_byte   = half_reg ? ltn_pkg::latin_lo(cmd_reg.data) :
                                            ltn_pkg::latin_hi(cmd_reg.data);
                    phase_done = half_reg;
                end
                else
                begin
                    res_byte   = cmd_reg.data;
                    phase_done = 1'b1;
                end
            end
            ST_NLEND:
            begin
                produce    = 1'b1;
                res_byte   = ltn_pkg::CH_LF;
                phase_done = 1'b1;
            end
            ST_BARE:
            begin
                produce    = 1'b1;
                res_val    = 1'b0;
                phase_done = 1'b1;
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase

        emit       = produce && emit_ok;
        next_after = first_phase(cmd_reg, {1'b0, state_reg} + 4'd1);
        is_last    = phase_done && (next_after == ST_IDLE);
        // read one ahead: one blank per cycle unless stalled
        raddr      = (state_reg == ST_BLANK && emit) ? idx_inc[ltn_pkg::BIDX_W-1:0] :
                                                       idx_reg[ltn_pkg::BIDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= 2'd0;
            half_reg  <= 1'b0;
            idx_reg   <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg <= first_phase(q_head, {1'b0, ST_HELD});
                k_reg     <= 2'd0;
                half_reg  <= 1'b0;
                idx_reg   <= '0;
            end
            else if (state_reg == ST_RD)
            begin
                state_reg <= ST_BLANK;
            end
            else if (emit)
            begin
                if (phase_done)
                begin
                    state_reg <= next_after;
                    k_reg     <= 2'd0;
                    half_reg  <= 1'b0;
                    idx_reg   <= '0;
                end
                else if (state_reg == ST_HELD)
                begin
                    if (unit_done)
                    begin
                        k_reg    <= k_reg + 2'd1;
                        half_reg <= 1'b0;
                    end
                    else
                    begin
                        half_reg <= 1'b1;
                    end
                end
                else if (state_reg == ST_BLANK)
                begin
                    idx_reg <= idx_inc;
                end
                else
                begin
                    half_reg <= 1'b1;
                end
            end

            if (emit)
            begin
                ovld_reg <= 1'b1;
            end
            else if (norm.ready)
            begin
                ovld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= q_head;
        end
        if (emit)
        begin
            obyte_reg <= res_byte;
            oval_reg  <= res_val;
            olast_reg <= is_last;
            odone_reg <= is_last && cmd_reg.msg_end;
            oovf_reg  <= cmd_reg.ovf;
        end
    end

    `LTN_ASSERT_NOW(a_bare_closes_msg, clk, rst_n, ovld_reg && !oval_reg, olast_reg && odone_reg)
    `LTN_ASSERT_NOW(a_done_is_last, clk, rst_n, ovld_reg && odone_reg, olast_reg)
    `LTN_ASSERT_NEXT(a_read_then_blank, clk, rst_n, state_reg == ST_RD, state_reg == ST_BLANK)
    `LTN_ASSERT_NOW(a_blank_in_range, clk, rst_n, state_reg == ST_BLANK, idx_reg < cmd_reg.blank_cnt)

endmodule

[hw/rtl/log_text_utf8_normalizer.sv]
// log text normaliser: raw message bytes in, normalised utf-8 bytes out
// raw channel: one item per input byte (byte_present) and/or message end
// (end_of_message); an end-only item carries no byte
// norm channel: one item per emitted byte; run_last marks the last item an
// input item caused, message_done the last of a message, and a bare end
// marker (out_valid low) appears when a message end causes nothing else
// ws_overflow is the sticky run-full flag as it stood after the input item
// the front end classifies each byte and pushes a command into a four-entry
// queue; the back end takes a command into a command register and expands it
// into output items, one per cycle while the receiver is ready, with a read
// of the blank store before a run of released blanks; items leave through
// the output register, and no new command is picked up until the last item
// of the current one has been emitted
// held blanks sit in a two-port store, written when their command is popped
// reset clears all control state; the blank store needs no clearing pass
// a stalled receiver holds the output register; the queue keeps taking
// input until it is full, then raw.ready drops
module log_text_utf8_normalizer (
    input  logic       clk,
    input  logic       rst_n,
    ltn_raw_if.sink    raw,
    ltn_norm_if.source norm
);

    ltn_pkg::cmd_t front_cmd;
    ltn_pkg::cmd_t q_head;
    logic          front_push;
    logic          q_full;
    logic          q_empty;
    logic          back_pop;

    ltn_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .raw    (raw),
        .q_full (q_full),
        .push   (front_push),
        .cmd    (front_cmd)
    );

    ltn_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (back_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    ltn_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (back_pop),
        .norm    (norm)
    );

endmodule
